>>> design/gdh_pkg.sv
// ----------------------------------------------------------------------------
// Grid density histogram package
// Shared constants, types and helper functions for the 3D histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdh_pkg;

  localparam int GridXDefault = 32;
  localparam int GridYDefault = 32;
  localparam int GridZDefault = 32;

  localparam int PosW   = 24;
  localparam int CellW  = 16;
  localparam int CountW = 32;
  localparam int BinW   = 5;
  localparam int IdxW   = 8;
  localparam int CfgIdxW = 3;
  localparam int DivSteps = PosW;
  localparam int StepW  = $clog2(DivSteps);

  localparam logic [CfgIdxW-1:0] CFG_LOW_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOW_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_Z  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CELL_X = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CELL_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CELL_Z = 3'd5;

  localparam logic [CellW-1:0] CellReset = 16'd256;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_INDEX,
    ST_READ,
    ST_UPDATE
  } gdh_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic index;
    logic mem_rd;
    logic update;
    logic clear;
  } gdh_cmd_t;

  typedef struct packed {
    logic kind;
    logic div_done;
    logic clear_last;
  } gdh_status_t;

  // Returns {clamped, index} for a quotient against a grid size.
  function automatic logic [IdxW:0] axis_clamp(input logic neg,
                                               input logic [PosW-1:0] q,
                                               input int grid);
    logic [IdxW:0] res;
    if (neg) begin
      res = {1'b1, {IdxW{1'b0}}};
    end else if (q >= PosW'(grid)) begin
      res = {1'b1, IdxW'(grid - 1)};
    end else begin
      res = {1'b0, q[IdxW-1:0]};
    end
    return res;
  endfunction

  function automatic logic [IdxW:0] read_clamp(input logic [BinW-1:0] r,
                                               input int grid);
    logic [IdxW:0] res;
    if (32'(r) >= 32'(grid)) begin
      res = {1'b1, IdxW'(grid - 1)};
    end else begin
      res = {1'b0, IdxW'(r)};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/gdh_ctrl.sv
// ----------------------------------------------------------------------------
// Grid density histogram controller
// Sequences the clearing pass, the division, the bin lookup and the update.
// ----------------------------------------------------------------------------
`default_nettype none

module gdh_ctrl import gdh_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  gdh_status_t status_i,
  output gdh_cmd_t    cmd_o
);

  gdh_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.kind) begin
          state_d = ST_INDEX;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_done) begin
            state_d = ST_INDEX;
          end
        end
      end
      ST_INDEX: begin
        cmd_o.index = 1'b1;
        state_d     = ST_READ;
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> state_q == ST_IDLE)
    else $error("update not followed by idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> !status_i.kind)
    else $error("division stepped for a read transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_DIV)
    else $error("load did not enter division");

endmodule

`default_nettype wire

>>> design/gdh_datapath.sv
// ----------------------------------------------------------------------------
// Grid density histogram datapath
// Configuration registers, three serial dividers, bin address and counter RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module gdh_datapath import gdh_pkg::*; #(
  parameter int GRID_X = GridXDefault,
  parameter int GRID_Y = GridYDefault,
  parameter int GRID_Z = GridZDefault
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire        [CfgIdxW-1:0] cfg_idx_i,
  input  wire        [PosW-1:0]    cfg_wdata_i,
  input  wire                      kind_i,
  input  wire signed [PosW-1:0]    pos_x_i,
  input  wire signed [PosW-1:0]    pos_y_i,
  input  wire signed [PosW-1:0]    pos_z_i,
  input  wire        [BinW-1:0]    read_x_i,
  input  wire        [BinW-1:0]    read_y_i,
  input  wire        [BinW-1:0]    read_z_i,
  input  gdh_cmd_t                 cmd_i,
  output gdh_status_t              status_o,
  output logic                     done_o,
  output logic       [BinW-1:0]    bin_x_o,
  output logic       [BinW-1:0]    bin_y_o,
  output logic       [BinW-1:0]    bin_z_o,
  output logic       [CountW-1:0]  count_o,
  output logic                     out_of_bounds_o
);

  localparam int Depth = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [PosW-1:0]  low_q  [3];
  logic [CellW-1:0] cell_q [3];
  logic [CellW-1:0] cell_eff [3];

  logic [CellW-1:0] rem_q [3];
  logic [CellW-1:0] rem_d [3];
  logic [PosW-1:0]  dq_q  [3];
  logic [PosW-1:0]  dq_d  [3];
  logic             neg_q [3];
  logic [StepW-1:0] step_q;
  logic             kind_q;
  logic [BinW-1:0]  rd_q [3];

  logic [IdxW:0]    cx, cy, cz;
  logic [IdxW-1:0]  idx_x_q, idx_y_q, idx_z_q;
  logic             clamp_q;
  logic [AW-1:0]    addr_q, addr_d;
  logic [31:0]      addr_full;
  logic [AW-1:0]    clear_addr_q;

  logic [CountW-1:0] mem [Depth];
  logic [CountW-1:0] rdata_q;
  logic [CountW-1:0] new_count;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CountW-1:0] mem_wdata;

  logic             done_q;
  logic [CountW-1:0] count_q;
  logic [IdxW-1:0]  out_x_q, out_y_q, out_z_q;
  logic             oob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q[0]  <= '0;
      low_q[1]  <= '0;
      low_q[2]  <= '0;
      cell_q[0] <= CellReset;
      cell_q[1] <= CellReset;
      cell_q[2] <= CellReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_X:  low_q[0]  <= cfg_wdata_i;
        CFG_LOW_Y:  low_q[1]  <= cfg_wdata_i;
        CFG_LOW_Z:  low_q[2]  <= cfg_wdata_i;
        CFG_CELL_X: cell_q[0] <= cfg_wdata_i[CellW-1:0];
        CFG_CELL_Y: cell_q[1] <= cfg_wdata_i[CellW-1:0];
        CFG_CELL_Z: cell_q[2] <= cfg_wdata_i[CellW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cell_eff[a] = (cell_q[a] == '0) ? CellW'(1) : cell_q[a];
    end
  end

  always_comb begin
    logic [CellW:0] r;
    r = '0;
    for (int a = 0; a < 3; a++) begin
      r = {rem_q[a], dq_q[a][PosW-1]};
      if (r >= {1'b0, cell_eff[a]}) begin
        rem_d[a] = CellW'(r - {1'b0, cell_eff[a]});
        dq_d[a]  = {dq_q[a][PosW-2:0], 1'b1};
      end else begin
        rem_d[a] = r[CellW-1:0];
        dq_d[a]  = {dq_q[a][PosW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [PosW:0] dx, dy, dz;
    dx = $signed({pos_x_i[PosW-1], pos_x_i}) - $signed({low_q[0][PosW-1], low_q[0]});
    dy = $signed({pos_y_i[PosW-1], pos_y_i}) - $signed({low_q[1][PosW-1], low_q[1]});
    dz = $signed({pos_z_i[PosW-1], pos_z_i}) - $signed({low_q[2][PosW-1], low_q[2]});
    if (cmd_i.load) begin
      dq_q[0]  <= dx[PosW-1:0];
      dq_q[1]  <= dy[PosW-1:0];
      dq_q[2]  <= dz[PosW-1:0];
      neg_q[0] <= dx[PosW];
      neg_q[1] <= dy[PosW];
      neg_q[2] <= dz[PosW];
      for (int a = 0; a < 3; a++) begin
        rem_q[a] <= '0;
      end
      rd_q[0] <= read_x_i;
      rd_q[1] <= read_y_i;
      rd_q[2] <= read_z_i;
    end else if (cmd_i.div_step) begin
      for (int a = 0; a < 3; a++) begin
        rem_q[a] <= rem_d[a];
        dq_q[a]  <= dq_d[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= '0;
      kind_q       <= 1'b0;
      clear_addr_q <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (cmd_i.load) begin
        step_q <= '0;
        kind_q <= kind_i;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + StepW'(1);
      end
      if (cmd_i.clear) begin
        clear_addr_q <= clear_addr_q + AW'(1);
      end
    end
  end

  always_comb begin
    if (kind_q) begin
      cx = read_clamp(rd_q[0], GRID_X);
      cy = read_clamp(rd_q[1], GRID_Y);
      cz = read_clamp(rd_q[2], GRID_Z);
    end else begin
      cx = axis_clamp(neg_q[0], dq_q[0], GRID_X);
      cy = axis_clamp(neg_q[1], dq_q[1], GRID_Y);
      cz = axis_clamp(neg_q[2], dq_q[2], GRID_Z);
    end
    addr_full = (32'(cz[IdxW-1:0]) * 32'(GRID_Y) + 32'(cy[IdxW-1:0])) * 32'(GRID_X)
                + 32'(cx[IdxW-1:0]);
    addr_d = addr_full[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.index) begin
      idx_x_q <= cx[IdxW-1:0];
      idx_y_q <= cy[IdxW-1:0];
      idx_z_q <= cz[IdxW-1:0];
      clamp_q <= cx[IdxW] | cy[IdxW] | cz[IdxW];
      addr_q  <= addr_d;
    end
  end

  assign new_count = (kind_q || rdata_q == '1) ? rdata_q : rdata_q + CountW'(1);
  assign mem_we    = cmd_i.clear | (cmd_i.update & ~kind_q);
  assign mem_waddr = cmd_i.clear ? clear_addr_q : addr_q;
  assign mem_wdata = cmd_i.clear ? '0 : new_count;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      count_q <= new_count;
      out_x_q <= idx_x_q;
      out_y_q <= idx_y_q;
      out_z_q <= idx_z_q;
      oob_q   <= clamp_q;
    end
  end

  assign status_o.kind       = kind_q;
  assign status_o.div_done   = step_q == StepW'(DivSteps - 1);
  assign status_o.clear_last = clear_addr_q == AW'(Depth - 1);

  assign done_o          = done_q;
  assign count_o         = count_q;
  assign bin_x_o         = out_x_q[BinW-1:0];
  assign bin_y_o         = out_y_q[BinW-1:0];
  assign bin_z_o         = out_z_q[BinW-1:0];
  assign out_of_bounds_o = oob_q;

endmodule

`default_nettype wire

>>> design/grid_density_histogram_3d.sv
// ----------------------------------------------------------------------------
// Grid density histogram 3D
// Bins fixed-point positions into a 3D grid of saturating 32-bit counters.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all GRID_X*GRID_Y*GRID_Z
// counters with busy high. Each transaction is then taken when start is
// high and busy is low. An accumulate transaction runs from acceptance to
// the done_o strobe through the three bit-serial dividers, one quotient bit
// per step, then the bin address, the counter RAM read, the update and the
// result register. A read transaction skips the dividers. The result is
// valid for the single cycle in which done_o is high and cannot be stalled.
`default_nettype none

module grid_density_histogram_3d import gdh_pkg::*; #(
  parameter int GRID_X = GridXDefault,
  parameter int GRID_Y = GridYDefault,
  parameter int GRID_Z = GridZDefault
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire        [CfgIdxW-1:0] cfg_idx_i,
  input  wire        [PosW-1:0]    cfg_wdata_i,
  input  wire                      start,
  output logic                     busy,
  input  wire                      kind_i,
  input  wire signed [PosW-1:0]    pos_x_i,
  input  wire signed [PosW-1:0]    pos_y_i,
  input  wire signed [PosW-1:0]    pos_z_i,
  input  wire        [BinW-1:0]    read_x_i,
  input  wire        [BinW-1:0]    read_y_i,
  input  wire        [BinW-1:0]    read_z_i,
  output logic                     done_o,
  output logic       [BinW-1:0]    bin_x_o,
  output logic       [BinW-1:0]    bin_y_o,
  output logic       [BinW-1:0]    bin_z_o,
  output logic       [CountW-1:0]  count_o,
  output logic                     out_of_bounds_o
);

  gdh_cmd_t    cmd;
  gdh_status_t status;

  gdh_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  gdh_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .kind_i          (kind_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .read_x_i        (read_x_i),
    .read_y_i        (read_y_i),
    .read_z_i        (read_z_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .done_o          (done_o),
    .bin_x_o         (bin_x_o),
    .bin_y_o         (bin_y_o),
    .bin_z_o         (bin_z_o),
    .count_o         (count_o),
    .out_of_bounds_o (out_of_bounds_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a transaction in flight");

endmodule

`default_nettype wire
